### design/mxs_pkg.sv
package mxs_pkg;

    localparam int PUSH_LEVELS_DEF  = 20;
    localparam int ELEMENT_BITS_DEF = 32;
    localparam int MAT_ELEMS        = 16;
    localparam int ELEM_IDX_BITS    = 4;
    localparam int LEVEL_OUT_BITS   = 5;
    localparam int ONE_Q16          = 32'h0001_0000;
    localparam int RND_HALF         = 32768;

    localparam logic [ELEM_IDX_BITS-1:0] IDX_LAST        = 4'd15;
    localparam logic [ELEM_IDX_BITS-1:0] IDX_XLATE_FIRST = 4'd12;
    localparam logic [ELEM_IDX_BITS-1:0] IDX_ROT_LAST    = 4'd11;
    localparam logic [1:0]               ROW_XLATE       = 2'd3;
    localparam logic [1:0]               COL_LAST        = 2'd2;

    typedef enum logic [3:0] {
        KIND_RESET      = 4'd0,
        KIND_PUSH_COPY  = 4'd1,
        KIND_PUSH_IDENT = 4'd2,
        KIND_POP        = 4'd3,
        KIND_IDENT      = 4'd4,
        KIND_CLR_XLATE  = 4'd5,
        KIND_CLR_ROT    = 4'd6,
        KIND_READ       = 4'd7,
        KIND_WRITE      = 4'd8,
        KIND_XLATE      = 4'd9
    } mxs_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } mxs_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COPY,
        ST_FILL,
        ST_READ,
        ST_X_RD,
        ST_X_MLO,
        ST_X_MHI,
        ST_X_SUM,
        ST_RESP
    } mxs_state_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
    } mxs_in_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [LEVEL_OUT_BITS-1:0] level;
        logic [3:0]                out_index;
        logic signed [31:0]        out_value;
        logic                      last;
    } mxs_out_t;

    typedef struct packed {
        logic base_clr;
        logic wr_en;
        logic rd_en;
    } mxs_mem_ctl_t;

    typedef struct packed {
        logic mul_en;
        logic mul_hi;
        logic acc_clr;
    } mxs_mac_ctl_t;

    function automatic logic [63:0] one_value(input int bits);
        logic [63:0] emax;
        emax = (64'd1 << (bits - 1)) - 64'd1;
        if (bits >= 18) begin
            return 64'(ONE_Q16);
        end
        return emax;
    endfunction

    function automatic logic is_diag(input logic [ELEM_IDX_BITS-1:0] idx);
        return idx[1:0] == idx[3:2];
    endfunction

endpackage

### design/mxs_store.sv
module mxs_store #(
    parameter int PUSH_LEVELS  = mxs_pkg::PUSH_LEVELS_DEF,
    parameter int ELEMENT_BITS = mxs_pkg::ELEMENT_BITS_DEF
) (
    input  logic                                                     aclk,
    input  logic                                                     aresetn,
    input  mxs_pkg::mxs_mem_ctl_t                                    ctl,
    input  logic [$clog2((PUSH_LEVELS+1)*mxs_pkg::MAT_ELEMS)-1:0]    wr_addr,
    input  logic signed [ELEMENT_BITS-1:0]                           wr_data,
    input  logic [$clog2((PUSH_LEVELS+1)*mxs_pkg::MAT_ELEMS)-1:0]    rd_addr,
    output logic signed [ELEMENT_BITS-1:0]                           rd_data
);
    import mxs_pkg::*;

    localparam int DEPTH = (PUSH_LEVELS + 1) * MAT_ELEMS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [63:0] ONE_W = one_value(ELEMENT_BITS);
    localparam logic [ELEMENT_BITS-1:0] ONE_VAL = ONE_W[ELEMENT_BITS-1:0];

    logic [ELEMENT_BITS-1:0]  mem [0:DEPTH-1];
    logic [ELEMENT_BITS-1:0]  mem_q_reg;
    logic [MAT_ELEMS-1:0]     base_vld_reg;
    logic                     dflt_reg;
    logic                     diag_reg;
    logic                     wr_base;
    logic                     rd_base;

    assign wr_base = wr_addr[AW-1:ELEM_IDX_BITS] == '0;
    assign rd_base = rd_addr[AW-1:ELEM_IDX_BITS] == '0;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            mem_q_reg <= mem[rd_addr];
            dflt_reg  <= rd_base && !base_vld_reg[rd_addr[ELEM_IDX_BITS-1:0]];
            diag_reg  <= is_diag(rd_addr[ELEM_IDX_BITS-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_vld_reg <= '0;
        end else if (ctl.base_clr) begin
            base_vld_reg <= '0;
        end else if (ctl.wr_en && wr_base) begin
            base_vld_reg[wr_addr[ELEM_IDX_BITS-1:0]] <= 1'b1;
        end
    end

    assign rd_data = dflt_reg ? (diag_reg ? ONE_VAL : '0) : mem_q_reg;

endmodule

### design/mxs_mac.sv
module mxs_mac #(
    parameter int ELEMENT_BITS = mxs_pkg::ELEMENT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mxs_pkg::mxs_mac_ctl_t          ctl,
    input  logic signed [ELEMENT_BITS-1:0] elem,
    input  logic signed [31:0]             delta,
    output logic signed [ELEMENT_BITS-1:0] sum
);
    import mxs_pkg::*;

    localparam int HI_BITS   = ELEMENT_BITS - 16;
    localparam int MA        = (HI_BITS > 17) ? HI_BITS : 17;
    localparam int PROD_BITS = MA + 32;
    localparam int SUM_BITS  = (PROD_BITS + 2 > ELEMENT_BITS + 18) ? PROD_BITS + 2
                                                                   : ELEMENT_BITS + 18;
    localparam logic [ELEMENT_BITS-1:0] EMAX_VAL = {1'b0, {(ELEMENT_BITS-1){1'b1}}};
    localparam logic [ELEMENT_BITS-1:0] EMIN_VAL = {1'b1, {(ELEMENT_BITS-1){1'b0}}};

    logic signed [MA-1:0]        mul_a;
    logic signed [PROD_BITS-1:0] mul_reg;
    logic                        pend_reg;
    logic                        pend_hi_reg;
    logic signed [PROD_BITS:0]   lo_rnd;
    logic signed [SUM_BITS-1:0]  contrib;
    logic signed [SUM_BITS-1:0]  acc_reg;
    logic signed [SUM_BITS-1:0]  total;
    logic                        fits;

    assign mul_a = ctl.mul_hi ? MA'(elem >>> 16)
                              : MA'($signed({1'b0, elem[15:0]}));

    assign lo_rnd  = (PROD_BITS+1)'(mul_reg) + (PROD_BITS+1)'(RND_HALF);
    assign contrib = pend_hi_reg ? SUM_BITS'(mul_reg) : SUM_BITS'(lo_rnd >>> 16);

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            mul_reg <= mul_a * delta;
        end
        if (ctl.acc_clr) begin
            acc_reg <= '0;
        end else if (pend_reg) begin
            acc_reg <= acc_reg + contrib;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            pend_hi_reg <= 1'b0;
        end else begin
            pend_reg    <= ctl.mul_en;
            pend_hi_reg <= ctl.mul_hi;
        end
    end

    assign total = acc_reg + SUM_BITS'(elem);
    assign fits  = (&total[SUM_BITS-1:ELEMENT_BITS-1]) | ~(|total[SUM_BITS-1:ELEMENT_BITS-1]);
    assign sum   = fits ? total[ELEMENT_BITS-1:0]
                        : (total[SUM_BITS-1] ? EMIN_VAL : EMAX_VAL);

endmodule

### design/mxs_ctrl.sv
module mxs_ctrl #(
    parameter int PUSH_LEVELS  = mxs_pkg::PUSH_LEVELS_DEF,
    parameter int ELEMENT_BITS = mxs_pkg::ELEMENT_BITS_DEF
) (
    input  logic                                                     aclk,
    input  logic                                                     aresetn,
    input  logic                                                     s_valid,
    output logic                                                     s_ready,
    input  mxs_pkg::mxs_in_t                                         s_data,
    output logic                                                     m_valid,
    input  logic                                                     m_ready,
    output mxs_pkg::mxs_out_t                                        m_data,
    output mxs_pkg::mxs_mem_ctl_t                                    mem_ctl,
    output logic [$clog2((PUSH_LEVELS+1)*mxs_pkg::MAT_ELEMS)-1:0]    wr_addr,
    output logic signed [ELEMENT_BITS-1:0]                           wr_data,
    output logic [$clog2((PUSH_LEVELS+1)*mxs_pkg::MAT_ELEMS)-1:0]    rd_addr,
    input  logic signed [ELEMENT_BITS-1:0]                           rd_data,
    output mxs_pkg::mxs_mac_ctl_t                                    mac_ctl,
    output logic signed [31:0]                                       mac_delta,
    input  logic signed [ELEMENT_BITS-1:0]                           mac_sum
);
    import mxs_pkg::*;

    localparam int DEPTH = (PUSH_LEVELS + 1) * MAT_ELEMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = AW - ELEM_IDX_BITS;
    localparam logic [LW-1:0] TOP_LEVEL = LW'(PUSH_LEVELS);
    localparam logic [63:0] ONE_W = one_value(ELEMENT_BITS);
    localparam logic [ELEMENT_BITS-1:0] ONE_VAL  = ONE_W[ELEMENT_BITS-1:0];
    localparam logic [ELEMENT_BITS-1:0] EMAX_VAL = {1'b0, {(ELEMENT_BITS-1){1'b1}}};
    localparam logic [ELEMENT_BITS-1:0] EMIN_VAL = {1'b1, {(ELEMENT_BITS-1){1'b0}}};

    mxs_state_t                state_reg, state_next;
    mxs_in_t                   item_reg, item_next;
    mxs_status_t               status_reg, status_next;
    logic [LW-1:0]             level_reg, level_next;
    logic [LW-1:0]             tgt_reg, tgt_next;
    logic [ELEM_IDX_BITS:0]    cnt_reg, cnt_next;
    logic [ELEM_IDX_BITS-1:0]  end_reg, end_next;
    logic [1:0]                r_reg, r_next;
    logic [1:0]                c_reg, c_next;
    logic                      m_valid_reg, m_valid_next;
    mxs_out_t                  m_data_reg, m_data_next;

    logic                      out_free;
    logic [ELEM_IDX_BITS:0]    cnt_m1;
    logic [ELEM_IDX_BITS-1:0]  cnt_idx;
    logic [ELEM_IDX_BITS-1:0]  cnt_idx_p1;
    logic signed [63:0]        wv_ext;
    logic                      wv_fits;
    logic [ELEMENT_BITS-1:0]   wv_sat;
    logic [ELEMENT_BITS-1:0]   ident_val;
    logic [ELEMENT_BITS+31:0]  rd_ext;
    logic [LW+LEVEL_OUT_BITS-1:0] lvl_wide;

    assign out_free   = !m_valid_reg || m_ready;
    assign cnt_m1     = cnt_reg - 1'b1;
    assign cnt_idx    = cnt_reg[ELEM_IDX_BITS-1:0];
    assign cnt_idx_p1 = cnt_idx + 1'b1;
    assign wv_ext     = 64'(item_reg.elem_value);
    assign wv_fits    = (&wv_ext[63:ELEMENT_BITS-1]) | ~(|wv_ext[63:ELEMENT_BITS-1]);
    assign wv_sat     = wv_fits ? wv_ext[ELEMENT_BITS-1:0] : (wv_ext[63] ? EMIN_VAL : EMAX_VAL);
    assign ident_val  = is_diag(cnt_idx) ? ONE_VAL : '0;
    assign rd_ext     = {{32{rd_data[ELEMENT_BITS-1]}}, rd_data};
    assign lvl_wide   = {{LEVEL_OUT_BITS{1'b0}}, level_reg};

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        status_reg <= status_next;
        tgt_reg    <= tgt_next;
        cnt_reg    <= cnt_next;
        end_reg    <= end_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        case (r_reg)
            2'd0:    mac_delta = item_reg.delta_x;
            2'd1:    mac_delta = item_reg.delta_y;
            default: mac_delta = item_reg.delta_z;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        status_next  = status_reg;
        level_next   = level_reg;
        tgt_next     = tgt_reg;
        cnt_next     = cnt_reg;
        end_next     = end_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        mem_ctl      = '0;
        mac_ctl      = '0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_addr      = '0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next   = s_data;
                    status_next = STATUS_OK;
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE: begin
                tgt_next   = level_reg;
                cnt_next   = '0;
                end_next   = IDX_LAST;
                state_next = ST_FILL;
                case (item_reg.kind)
                    KIND_RESET: begin
                        mem_ctl.base_clr = 1'b1;
                        level_next       = '0;
                        state_next       = ST_RESP;
                    end
                    KIND_PUSH_COPY, KIND_PUSH_IDENT: begin
                        tgt_next = level_reg + 1'b1;
                        if (level_reg == TOP_LEVEL) begin
                            status_next = STATUS_OVERFLOW;
                            state_next  = ST_RESP;
                        end else if (item_reg.kind == KIND_PUSH_COPY) begin
                            state_next = ST_COPY;
                        end
                    end
                    KIND_POP: begin
                        if (level_reg == '0) begin
                            status_next = STATUS_UNDERFLOW;
                        end else begin
                            level_next = level_reg - 1'b1;
                        end
                        state_next = ST_RESP;
                    end
                    KIND_IDENT: begin
                        state_next = ST_FILL;
                    end
                    KIND_CLR_XLATE: begin
                        cnt_next = {1'b0, IDX_XLATE_FIRST};
                    end
                    KIND_CLR_ROT: begin
                        end_next = IDX_ROT_LAST;
                    end
                    KIND_READ: begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = {level_reg, {ELEM_IDX_BITS{1'b0}}};
                        state_next    = ST_READ;
                    end
                    KIND_WRITE: begin
                        cnt_next = {1'b0, item_reg.elem_index};
                        end_next = item_reg.elem_index;
                    end
                    KIND_XLATE: begin
                        mac_ctl.acc_clr = 1'b1;
                        r_next          = '0;
                        c_next          = '0;
                        state_next      = ST_X_RD;
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_COPY: begin
                mem_ctl.rd_en = !cnt_reg[ELEM_IDX_BITS];
                rd_addr       = {level_reg, cnt_idx};
                mem_ctl.wr_en = cnt_reg != '0;
                wr_addr       = {tgt_reg, cnt_m1[ELEM_IDX_BITS-1:0]};
                wr_data       = rd_data;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg[ELEM_IDX_BITS]) begin
                    level_next = tgt_reg;
                    state_next = ST_RESP;
                end
            end

            ST_FILL: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = {tgt_reg, cnt_idx};
                wr_data       = (item_reg.kind == KIND_WRITE) ? wv_sat : ident_val;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_idx == end_reg) begin
                    level_next = tgt_reg;
                    state_next = ST_RESP;
                end
            end

            ST_READ: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = STATUS_OK;
                    m_data_next.level     = lvl_wide[LEVEL_OUT_BITS-1:0];
                    m_data_next.out_index = cnt_idx;
                    m_data_next.out_value = rd_ext[31:0];
                    m_data_next.last      = cnt_idx == IDX_LAST;
                    if (cnt_idx == IDX_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = {level_reg, cnt_idx_p1};
                        cnt_next      = cnt_reg + 1'b1;
                    end
                end
            end

            ST_X_RD: begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = {level_reg, r_reg, c_reg};
                state_next    = (r_reg == ROW_XLATE) ? ST_X_SUM : ST_X_MLO;
            end

            ST_X_MLO: begin
                mac_ctl.mul_en = 1'b1;
                state_next     = ST_X_MHI;
            end

            ST_X_MHI: begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.mul_hi = 1'b1;
                r_next         = r_reg + 1'b1;
                state_next     = ST_X_RD;
            end

            ST_X_SUM: begin
                mem_ctl.wr_en   = 1'b1;
                wr_addr         = {level_reg, ROW_XLATE, c_reg};
                wr_data         = mac_sum;
                mac_ctl.acc_clr = 1'b1;
                r_next          = '0;
                c_next          = c_reg + 1'b1;
                state_next      = (c_reg == COL_LAST) ? ST_RESP : ST_X_RD;
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = status_reg;
                    m_data_next.level     = lvl_wide[LEVEL_OUT_BITS-1:0];
                    m_data_next.out_index = '0;
                    m_data_next.out_value = '0;
                    m_data_next.last      = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/matrix_stack_4x4.sv
// Channel  Ports                       Direction  Contents
// s_       s_valid s_ready s_data      in         one operation transaction (mxs_in_t)
// m_       m_valid m_ready m_data      out        one result transaction (mxs_out_t)
//
// One transaction at a time; s_ready is high only while the sequencer is idle.
// Push copy reads each element of the current level and writes it one level up (one
// read port and one write port, one element read and written per cycle); push identity
// and identity fill a matrix with identity; read returns its 16 results; translate uses
// one shared 17x32 multiplier, two passes per product. The sequencer then returns to idle.
// Reset clears the level and the base-matrix valid bits; the base reads as
// identity until written. A stalled m_ready holds the result; the next
// transaction is still taken while the result waits.
module matrix_stack_4x4 #(
    parameter int PUSH_LEVELS  = mxs_pkg::PUSH_LEVELS_DEF,
    parameter int ELEMENT_BITS = mxs_pkg::ELEMENT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mxs_pkg::mxs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mxs_pkg::mxs_out_t m_data
);
    import mxs_pkg::*;

    localparam int DEPTH = (PUSH_LEVELS + 1) * MAT_ELEMS;
    localparam int AW    = $clog2(DEPTH);

    mxs_mem_ctl_t                  mem_ctl;
    mxs_mac_ctl_t                  mac_ctl;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    logic signed [ELEMENT_BITS-1:0] wr_data;
    logic signed [ELEMENT_BITS-1:0] rd_data;
    logic signed [31:0]            mac_delta;
    logic signed [ELEMENT_BITS-1:0] mac_sum;

    mxs_store #(
        .PUSH_LEVELS  (PUSH_LEVELS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mxs_mac #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .elem    (rd_data),
        .delta   (mac_delta),
        .sum     (mac_sum)
    );

    mxs_ctrl #(
        .PUSH_LEVELS  (PUSH_LEVELS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mem_ctl   (mem_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .mac_ctl   (mac_ctl),
        .mac_delta (mac_delta),
        .mac_sum   (mac_sum)
    );

    a_no_rw_same_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_ctl.rd_en && mem_ctl.wr_en |-> rd_addr != wr_addr)
        else $error("memory read and write hit the same entry");

    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_ctl.wr_en |-> {1'b0, wr_addr} < (AW+1)'(DEPTH))
        else $error("write beyond the matrix store");

    a_mul_stable_data: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_ctl.mul_en |-> !mem_ctl.rd_en)
        else $error("memory read overlaps a multiply");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted while busy");

endmodule
